FILE: rtl/rsbk_pkg.sv
// Package for the record sorter: capacity, counter width and the payload
// and control structs used by the cell and the top level.
// Depends on nothing.
`default_nettype none

package rsbk_pkg;

    // Number of cells in the chain, and so the most records a set can hold.
    localparam int CAPACITY = 64;
    // Width of a count that ranges from zero up to CAPACITY.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int KEY_W = 24;
    localparam int TAG_W = 16;

    // One record as held in a cell.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

    // One input request.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } in_t;

    // One sorted result.
    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             final_res;
        logic             overflow;
    } out_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage : rsbk_pkg

`default_nettype wire

FILE: rtl/rsbk_cell.sv
// One cell of the insertion chain: holds one record, decides whether a new
// record displaces it, and shifts toward the head while the set drains.
// Depends on rsbk_pkg.
`default_nettype none

module rsbk_cell (
    input  wire logic               clk,
    input  wire rsbk_pkg::cell_ctrl_t ctrl,
    input  wire rsbk_pkg::rec_t     new_rec,
    input  wire rsbk_pkg::rec_t     prev_rec,
    input  wire logic               prev_gt,
    input  wire rsbk_pkg::rec_t     next_rec,
    input  wire logic               empty,
    output rsbk_pkg::rec_t          rec,
    output logic                    gt
);
    import rsbk_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // An empty cell counts as holding a key above any other. Only a strictly
    // greater key is displaced, so equal keys keep their load order.
    assign gt = empty || (rec_reg.key > new_rec.key);

    // Drain shifts toward the head; insert either takes the new record or
    // the neighbor's record pushed along by it.
    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.drain)
        begin
            rec_next = next_rec;
        end
        else if (ctrl.insert && gt)
        begin
            rec_next = prev_gt ? prev_rec : new_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule : rsbk_cell

`default_nettype wire

FILE: rtl/record_sort_by_key.sv
// Top level of the record sorter: a chain of insertion cells plus the fill
// count and drain control.
// Depends on rsbk_pkg and rsbk_cell.
//
// Usage: a request (key, tag, last) is taken at a rising edge where start is
// high and busy is low. Loading takes one request per cycle: each record is
// placed in sorted position by the cell chain in the cycle it is taken, and
// equal keys stay in load order. Records taken while all CAPACITY cells are
// full are dropped and remembered.
// A request with last set starts the drain: busy rises in the next cycle and
// the held records leave from the head cell in ascending key order, one per
// cycle, each marked by strobe for exactly one cycle. The first result comes
// in the cycle after the last request, and each drain step shifts the chain
// one place toward its head. The final result has final_res set and overflow
// set if any record of the set was dropped. busy falls after the final
// result and the block is ready for a new set.
// The receiver cannot stall; results must be taken when strobe is high.
// Reset clears the fill count, the drop flag and the drain state at once.
`default_nettype none

module record_sort_by_key (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rsbk_pkg::in_t  request,
    output logic                strobe,
    output rsbk_pkg::out_t      result
);
    import rsbk_pkg::*;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             drain_reg;
    logic             drain_next;

    logic             accept;
    logic             full;
    cell_ctrl_t       ctrl;
    rec_t             new_rec;
    rec_t             cell_rec [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;

    assign accept  = start && !busy;
    assign full    = (fill_reg == CNT_W'(CAPACITY));
    assign new_rec = '{key: request.key, tag: request.tag};

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = drain_reg;

    // The cell chain; cell zero is the head and holds the smallest key.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic cell_empty;
        rec_t prev_r;
        rec_t next_r;
        logic prev_g;

        assign cell_empty = (CNT_W'(i) >= fill_reg);

        if (i == 0)
        begin : g_head
            assign prev_r = new_rec;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_r = cell_rec[i-1];
            assign prev_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_r = cell_rec[i];
        end
        else
        begin : g_inner
            assign next_r = cell_rec[i+1];
        end

        rsbk_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .new_rec  (new_rec),
            .prev_rec (prev_r),
            .prev_gt  (prev_g),
            .next_rec (next_r),
            .empty    (cell_empty),
            .rec      (cell_rec[i]),
            .gt       (cell_gt[i])
        );
    end

    // Fill count, drop flag and drain control.
    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        drain_next   = drain_reg;
        if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            if (request.last)
            begin
                drain_next = 1'b1;
            end
        end
        else if (drain_reg)
        begin
            fill_next = fill_reg - CNT_W'(1);
            if (fill_reg == CNT_W'(1))
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            drain_reg   <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            drain_reg   <= drain_next;
        end
    end

    // Results leave from the head cell while draining.
    assign busy              = drain_reg;
    assign strobe            = drain_reg;
    assign result.sorted_key = cell_rec[0].key;
    assign result.sorted_tag = cell_rec[0].tag;
    assign result.final_res  = (fill_reg == CNT_W'(1));
    assign result.overflow   = (fill_reg == CNT_W'(1)) && dropped_reg;

endmodule : record_sort_by_key

`default_nettype wire
